@@ rtl/core/vss_pkg.sv @@
// ----------------------------------------------------------------------------
// vss_pkg
// Shared constants and control types for the voxel set subtract block.
// ----------------------------------------------------------------------------
package vss_pkg;

  localparam int unsigned ToolDepthDef = 64;
  localparam int unsigned WorkDepthDef = 64;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned CoordW = 16;
  localparam int unsigned VoxW   = 3 * CoordW;

  // command codes carried on the input tuser
  localparam logic [CmdW-1:0] CMD_TOOL_CLR = 3'd0;
  localparam logic [CmdW-1:0] CMD_TOOL_APP = 3'd1;
  localparam logic [CmdW-1:0] CMD_WORK_CLR = 3'd2;
  localparam logic [CmdW-1:0] CMD_WORK_APP = 3'd3;
  localparam logic [CmdW-1:0] CMD_CUT      = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic tool_clr;
    logic tool_app;
    logic work_clr;
    logic work_app;
    logic cut_start;   // rewind walk, drop pending survivor
    logic work_next;   // advance to next workpiece voxel
    logic scan_start;  // rewind tool scan
    logic scan_next;   // advance tool scan
    logic keep;        // write back survivor, emit the pending one
    logic finish;      // emit final result, commit new count
  } vss_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic work_done;  // walk index reached the workpiece count
    logic tool_none;  // tool set empty
    logic tool_hit;   // current tool voxel equals current workpiece voxel
    logic tool_end;   // current tool voxel is the last one
    logic out_free;   // output register can take a result this cycle
  } vss_sts_t;

endpackage

@@ rtl/core/vss_ctrl.sv @@
// ----------------------------------------------------------------------------
// vss_ctrl
// Command decode and cut sequencer for the voxel set subtract block.
// ----------------------------------------------------------------------------
module vss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic [vss_pkg::CmdW-1:0]    req_cmd_i,
  output logic                        req_ready_o,
  input  vss_pkg::vss_sts_t           sts_i,
  output vss_pkg::vss_ctl_t           ctl_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_W_RD   = 3'd1;
  localparam logic [2:0] ST_W_CHK  = 3'd2;
  localparam logic [2:0] ST_T_RD   = 3'd3;
  localparam logic [2:0] ST_T_CMP  = 3'd4;
  localparam logic [2:0] ST_KEEP   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_cmd_i)
            vss_pkg::CMD_TOOL_CLR: ctl_o.tool_clr = 1'b1;
            vss_pkg::CMD_TOOL_APP: ctl_o.tool_app = 1'b1;
            vss_pkg::CMD_WORK_CLR: ctl_o.work_clr = 1'b1;
            vss_pkg::CMD_WORK_APP: ctl_o.work_app = 1'b1;
            vss_pkg::CMD_CUT: begin
              ctl_o.cut_start = 1'b1;
              state_d         = ST_W_RD;
            end
            default: ;
          endcase
        end
      end
      ST_W_RD: begin
        // read of the workpiece voxel is in flight
        if (sts_i.work_done) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_W_CHK;
        end
      end
      ST_W_CHK: begin
        if (sts_i.tool_none) begin
          state_d = ST_KEEP;
        end else begin
          ctl_o.scan_start = 1'b1;
          state_d          = ST_T_RD;
        end
      end
      ST_T_RD: begin
        state_d = ST_T_CMP;
      end
      ST_T_CMP: begin
        if (sts_i.tool_hit) begin
          // drop this workpiece voxel
          ctl_o.work_next = 1'b1;
          state_d         = ST_W_RD;
        end else if (sts_i.tool_end) begin
          state_d = ST_KEEP;
        end else begin
          ctl_o.scan_next = 1'b1;
          state_d         = ST_T_RD;
        end
      end
      ST_KEEP: begin
        if (sts_i.out_free) begin
          ctl_o.keep      = 1'b1;
          ctl_o.work_next = 1'b1;
          state_d         = ST_W_RD;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/vss_datapath.sv @@
// ----------------------------------------------------------------------------
// vss_datapath
// Voxel stores, counters, compare and output register.
// ----------------------------------------------------------------------------
module vss_datapath #(
  parameter int unsigned TOOL_DEPTH = vss_pkg::ToolDepthDef,
  parameter int unsigned WORK_DEPTH = vss_pkg::WorkDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vss_pkg::VoxW-1:0]    vox_i,
  input  vss_pkg::vss_ctl_t           ctl_i,
  output vss_pkg::vss_sts_t           sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [vss_pkg::VoxW-1:0]    out_vox_o,
  output logic                        out_present_o,
  output logic                        out_last_o,
  output logic                        out_overflow_o
);

  localparam int unsigned TCW = $clog2(TOOL_DEPTH + 1);
  localparam int unsigned WCW = $clog2(WORK_DEPTH + 1);
  localparam int unsigned TAW = (TOOL_DEPTH > 1) ? $clog2(TOOL_DEPTH) : 1;
  localparam int unsigned WAW = (WORK_DEPTH > 1) ? $clog2(WORK_DEPTH) : 1;

  logic [vss_pkg::VoxW-1:0] tool_mem [TOOL_DEPTH];
  logic [vss_pkg::VoxW-1:0] work_mem [WORK_DEPTH];
  logic [vss_pkg::VoxW-1:0] tool_rd_q;
  logic [vss_pkg::VoxW-1:0] work_rd_q;

  logic [TCW-1:0] tool_cnt_q, tool_cnt_d;
  logic [WCW-1:0] work_cnt_q, work_cnt_d;
  logic [TCW-1:0] scan_q, scan_d;
  logic [WCW-1:0] walk_q, walk_d;
  logic [WCW-1:0] kept_q, kept_d;
  logic           ovf_q, ovf_d;
  logic           pend_vld_q, pend_vld_d;
  logic [vss_pkg::VoxW-1:0] pend_q;

  logic           out_vld_q, out_vld_d;
  logic [vss_pkg::VoxW-1:0] out_vox_q;
  logic           out_pres_q, out_last_q, out_ovf_q;

  logic tool_full, work_full;
  logic tool_wr, work_wr;
  logic [WAW-1:0] work_waddr;
  logic [vss_pkg::VoxW-1:0] work_wdata;
  logic emit;

  assign tool_full = (tool_cnt_q == TCW'(TOOL_DEPTH));
  assign work_full = (work_cnt_q == WCW'(WORK_DEPTH));
  assign tool_wr   = ctl_i.tool_app && !tool_full;
  assign work_wr   = (ctl_i.work_app && !work_full) || ctl_i.keep;
  assign work_waddr = ctl_i.keep ? kept_q[WAW-1:0] : work_cnt_q[WAW-1:0];
  assign work_wdata = ctl_i.keep ? work_rd_q : vox_i;

  always_ff @(posedge clk_i) begin
    if (tool_wr) begin
      tool_mem[tool_cnt_q[TAW-1:0]] <= vox_i;
    end
    tool_rd_q <= tool_mem[scan_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (work_wr) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_q <= work_mem[walk_q[WAW-1:0]];
  end

  assign sts_o.work_done = (walk_q == work_cnt_q);
  assign sts_o.tool_none = (tool_cnt_q == '0);
  assign sts_o.tool_hit  = (tool_rd_q == work_rd_q);
  assign sts_o.tool_end  = (TCW'(scan_q + TCW'(1)) == tool_cnt_q);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign emit = (ctl_i.keep && pend_vld_q) || ctl_i.finish;

  always_comb begin
    tool_cnt_d = tool_cnt_q;
    work_cnt_d = work_cnt_q;
    scan_d     = scan_q;
    walk_d     = walk_q;
    kept_d     = kept_q;
    ovf_d      = ovf_q;
    pend_vld_d = pend_vld_q;

    if (ctl_i.tool_clr) tool_cnt_d = '0;
    if (ctl_i.work_clr) work_cnt_d = '0;
    if (ctl_i.tool_app) begin
      if (tool_full) ovf_d = 1'b1;
      else           tool_cnt_d = TCW'(tool_cnt_q + TCW'(1));
    end
    if (ctl_i.work_app) begin
      if (work_full) ovf_d = 1'b1;
      else           work_cnt_d = WCW'(work_cnt_q + WCW'(1));
    end
    if (ctl_i.cut_start) begin
      walk_d     = '0;
      kept_d     = '0;
      pend_vld_d = 1'b0;
    end
    if (ctl_i.work_next)  walk_d = WCW'(walk_q + WCW'(1));
    if (ctl_i.scan_start) scan_d = '0;
    if (ctl_i.scan_next)  scan_d = TCW'(scan_q + TCW'(1));
    if (ctl_i.keep) begin
      kept_d     = WCW'(kept_q + WCW'(1));
      pend_vld_d = 1'b1;
    end
    if (ctl_i.finish) work_cnt_d = kept_q;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit)             out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tool_cnt_q <= '0;
      work_cnt_q <= '0;
      scan_q     <= '0;
      walk_q     <= '0;
      kept_q     <= '0;
      ovf_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      tool_cnt_q <= tool_cnt_d;
      work_cnt_q <= work_cnt_d;
      scan_q     <= scan_d;
      walk_q     <= walk_d;
      kept_q     <= kept_d;
      ovf_q      <= ovf_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.keep) begin
      pend_q <= work_rd_q;
    end
    if (emit) begin
      // hold back each survivor until the next one shows it is not the last
      out_vox_q  <= (ctl_i.finish && !pend_vld_q) ? '0 : pend_q;
      out_pres_q <= ctl_i.keep || pend_vld_q;
      out_last_q <= ctl_i.finish;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_vox_o      = out_vox_q;
  assign out_present_o  = out_pres_q;
  assign out_last_o     = out_last_q;
  assign out_overflow_o = out_ovf_q;

endmodule

@@ rtl/core/voxel_set_subtract_top.sv @@
// ----------------------------------------------------------------------------
// voxel_set_subtract_top
// Workpiece minus tool voxel subtraction over two appended voxel sets.
// ----------------------------------------------------------------------------
// Clear and append requests produce no result. A cut is accepted, then
// reads and checks each workpiece voxel, runs a tool store read then compare
// per tool voxel compared, writes back each survivor and finishes with a
// last index check then the final result; a full output register stalls the
// survivor and finish steps. Reset clears the set counts, the overflow flag
// and the sequencer; the voxel stores keep undefined contents until written.
module voxel_set_subtract_top #(
  parameter int unsigned TOOL_DEPTH = vss_pkg::ToolDepthDef,
  parameter int unsigned WORK_DEPTH = vss_pkg::WorkDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // vox_x [15:0], vox_y [31:16], vox_z [47:32]
  input  logic [2:0]  s_axis_tuser,   // cmd [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_x [15:0], out_y [31:16], out_z [47:32]
  output logic [1:0]  m_axis_tuser,   // present [0], overflowed [1]
  output logic        m_axis_tlast    // last_item
);

  vss_pkg::vss_ctl_t ctl;
  vss_pkg::vss_sts_t sts;
  logic [vss_pkg::VoxW-1:0] out_vox;
  logic out_present, out_overflow;

  vss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_cmd_i   (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  vss_datapath #(
    .TOOL_DEPTH (TOOL_DEPTH),
    .WORK_DEPTH (WORK_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vox_i          (s_axis_tdata),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_vox_o      (out_vox),
    .out_present_o  (out_present),
    .out_last_o     (m_axis_tlast),
    .out_overflow_o (out_overflow)
  );

  assign m_axis_tdata = out_vox;
  assign m_axis_tuser = {out_overflow, out_present};

endmodule
